>>> rtl/core/aks_pkg.sv
// Shared types and constants for the ascending key sorter.
// No dependencies; the channel interfaces and all modules use it.
package aks_pkg;

  // Fixed width of the key fields on both channels.
  localparam int unsigned PORT_KEY_BITS = 32;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the broadcast key, shift larger keys right
    logic shift;   // move every key one cell toward the head
  } cell_ctrl_t;

endpackage

>>> rtl/core/aks_if.sv
// Valid/ready channel interfaces for keys in and sorted results out.
// Depends on aks_pkg for the key field width.
interface aks_key_if;
  logic                                 valid;
  logic                                 ready;
  logic [aks_pkg::PORT_KEY_BITS-1:0]    key;
  logic                                 last_item;

  modport source (output valid, output key, output last_item, input ready);
  modport sink   (input valid, input key, input last_item, output ready);
endinterface

interface aks_result_if;
  logic                                 valid;
  logic                                 ready;
  logic [aks_pkg::PORT_KEY_BITS-1:0]    sorted_key;
  logic                                 last_result;
  logic                                 overflowed;

  modport source (output valid, output sorted_key, output last_result, output overflowed,
                  input ready);
  modport sink   (input valid, input sorted_key, input last_result, input overflowed,
                  output ready);
endinterface

>>> rtl/core/aks_cell.sv
// One cell of the insertion chain: holds a key and its valid flag.
// Depends on aks_pkg for the cell command struct.
module aks_cell #(
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  aks_pkg::cell_ctrl_t     ctrl,
  input  logic [KEY_WIDTH-1:0]    new_key,
  input  logic                    prev_valid,
  input  logic [KEY_WIDTH-1:0]    prev_key,
  input  logic                    prev_before,
  input  logic                    next_valid,
  input  logic [KEY_WIDTH-1:0]    next_key,
  output logic                    valid,
  output logic [KEY_WIDTH-1:0]    key,
  output logic                    ahead
);

  // The new key belongs at or ahead of this cell.
  assign ahead = !valid || ($signed(new_key) < $signed(key));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= next_valid;
    end else if (ctrl.insert) begin
      if (prev_before) begin
        valid <= prev_valid;
      end else if (ahead) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key <= next_key;
    end else if (ctrl.insert) begin
      if (prev_before) begin
        key <= prev_key;
      end else if (ahead) begin
        key <= new_key;
      end
    end
  end

endmodule

>>> rtl/core/ascending_key_sorter.sv
// Ascending key sorter: a chain of MAX_ITEMS insertion cells.
// Load takes one key per cycle while not draining; each key lands in sorted
// place at its request. The last key taken sets draining; results then drain from
// the chain head into the output register, one per cycle while the receiver is ready.
// Synchronous active-high reset empties the chain and clears the overflow flag.
// Depends on aks_pkg, aks_if (channel interfaces) and aks_cell.
module ascending_key_sorter #(
  parameter int unsigned MAX_ITEMS = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  aks_key_if.sink              keys,
  aks_result_if.source         results
);

  localparam int unsigned PW = aks_pkg::PORT_KEY_BITS;

  logic [MAX_ITEMS-1:0]  cell_valid;
  logic [MAX_ITEMS-1:0]  cell_before;
  logic [KEY_WIDTH-1:0]  cell_key [MAX_ITEMS];
  logic [KEY_WIDTH-1:0]  new_key;
  logic [PW-1:0]         head_key;
  aks_pkg::cell_ctrl_t   ctrl;

  logic                  draining;
  logic                  overflow_seen;
  logic                  out_valid;
  logic [PW-1:0]         out_key;
  logic                  out_last;
  logic                  out_ovf;

  logic in_take;
  logic out_load;
  logic full;
  logic run_end;

  // Width adaptation between the 32-bit channel fields and the internal key.
  generate
    if (KEY_WIDTH == PW) begin : g_equal
      assign new_key  = keys.key;
      assign head_key = cell_key[0];
    end else if (KEY_WIDTH < PW) begin : g_narrow
      assign new_key  = keys.key[KEY_WIDTH-1:0];
      assign head_key = {{(PW-KEY_WIDTH){1'b0}}, cell_key[0]} ;
    end else begin : g_wide
      assign new_key  = {{(KEY_WIDTH-PW){1'b0}}, keys.key};
      assign head_key = cell_key[0][PW-1:0];
    end
  endgenerate

  assign full     = cell_valid[MAX_ITEMS-1];
  assign in_take  = keys.valid && keys.ready;
  assign out_load = draining && (!out_valid || results.ready);
  assign run_end  = out_load && !cell_valid[1];

  assign keys.ready  = !draining;
  assign ctrl.insert = in_take && !full;
  assign ctrl.shift  = out_load;

  generate
    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic                 p_valid;
      logic [KEY_WIDTH-1:0] p_key;
      logic                 p_before;
      logic                 n_valid;
      logic [KEY_WIDTH-1:0] n_key;

      if (i == 0) begin : g_head
        assign p_valid  = 1'b0;
        assign p_key    = '0;
        assign p_before = 1'b0;
      end else begin : g_mid
        assign p_valid  = cell_valid[i-1];
        assign p_key    = cell_key[i-1];
        assign p_before = cell_before[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_tail
        assign n_valid = 1'b0;
        assign n_key   = '0;
      end else begin : g_body
        assign n_valid = cell_valid[i+1];
        assign n_key   = cell_key[i+1];
      end

      aks_cell #(
        .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .new_key     (new_key),
        .prev_valid  (p_valid),
        .prev_key    (p_key),
        .prev_before (p_before),
        .next_valid  (n_valid),
        .next_key    (n_key),
        .valid       (cell_valid[i]),
        .key         (cell_key[i]),
        .ahead       (cell_before[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      draining      <= 1'b0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (in_take && keys.last_item) begin
        draining <= 1'b1;
      end else if (run_end) begin
        draining <= 1'b0;
      end

      if (in_take && full) begin
        overflow_seen <= 1'b1;
      end else if (run_end) begin
        overflow_seen <= 1'b0;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_key  <= head_key;
      out_last <= !cell_valid[1];
      out_ovf  <= overflow_seen || (in_take && full);
    end
  end

  assign results.valid       = out_valid;
  assign results.sorted_key  = out_key;
  assign results.last_result = out_last;
  assign results.overflowed  = out_ovf;

  // Occupied cells always form a prefix of the chain.
  logic [MAX_ITEMS:0] fill_mark;
  assign fill_mark = {1'b0, cell_valid} + {{MAX_ITEMS{1'b0}}, 1'b1};

  a_prefix_fill: assert property (@(posedge clk) disable iff (rst)
    $onehot(fill_mark))
    else $error("chain occupancy is not a prefix");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    draining |-> cell_valid[0])
    else $error("draining with an empty chain");

  a_last_ends_drain: assert property (@(posedge clk) disable iff (rst)
    run_end |=> (!draining && !cell_valid[0]))
    else $error("chain not empty after the final result");

  a_overflow_flag: assert property (@(posedge clk) disable iff (rst)
    (in_take && full) |=> overflow_seen)
    else $error("dropped key did not raise overflow");

endmodule

>>> test/tb.sv
// Self-checking bench for ascending_key_sorter: key sets in, sorted runs out.
// Depends on aks_pkg, aks_if and the sorter RTL; keeps its own sorted
// model of the held keys and checks every result request against it.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef logic signed [aks_pkg::PORT_KEY_BITS-1:0] key_t;

  typedef struct packed {
    logic [aks_pkg::PORT_KEY_BITS-1:0] sorted_key;
    logic                              last_result;
    logic                              overflowed;
  } sorted_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  aks_key_if    keys_ch();
  aks_result_if results_ch();

  ascending_key_sorter #(
    .MAX_ITEMS(STORE_DEPTH),
    .KEY_WIDTH(aks_pkg::PORT_KEY_BITS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .keys   (keys_ch),
    .results(results_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // model state: keys kept in ascending order as they arrive
  key_t           held_keys[$];
  logic           set_overflowed;
  sorted_result_t expected_results[$];

  int key_idle_pct;
  int result_idle_pct;
  int fail_count;
  int idle_cycles;

  // Stable insertion keeps equal keys in arrival order; order among equals
  // is invisible at the output anyway.
  task automatic record_key(input key_t k, input logic last);
    int pos;
    sorted_result_t r;
    if (held_keys.size() < STORE_DEPTH) begin
      pos = held_keys.size();
      for (int i = 0; i < held_keys.size(); i++) begin
        if (held_keys[i] > k) begin
          pos = i;
          break;
        end
      end
      held_keys.insert(pos, k);
    end else begin
      set_overflowed = 1'b1;
    end
    if (last) begin
      for (int i = 0; i < held_keys.size(); i++) begin
        r.sorted_key  = held_keys[i];
        r.last_result = (i == held_keys.size() - 1);
        r.overflowed  = set_overflowed;
        expected_results.push_back(r);
      end
      held_keys.delete();
      set_overflowed = 1'b0;
    end
  endtask

  // valid is left high after the request so back-to-back keys never
  // see a low/high pair in the same step
  task automatic send_key(input key_t k, input logic last);
    while ($urandom_range(99) < key_idle_pct) begin
      keys_ch.valid <= 1'b0;
      @(posedge clk);
    end
    keys_ch.valid     <= 1'b1;
    keys_ch.key       <= k;
    keys_ch.last_item <= last;
    @(posedge clk);
    while (!keys_ch.ready) @(posedge clk);
    record_key(k, last);
  endtask

  function automatic key_t random_key();
    case ($urandom_range(3))
      0: random_key = $urandom_range(8) - 4;  // dense, forces duplicates
      1: begin
        case ($urandom_range(3))
          0: random_key = 32'sh7fffffff;
          1: random_key = 32'sh80000000;
          2: random_key = 32'sh00000000;
          default: random_key = 32'shffffffff;
        endcase
      end
      default: random_key = $urandom;
    endcase
  endfunction

  task automatic send_set(input key_t set_keys[$]);
    for (int i = 0; i < set_keys.size(); i++)
      send_key(set_keys[i], i == set_keys.size() - 1);
  endtask

  task automatic test_directed();
    send_set('{32'sh7fffffff});
    send_set('{32'sh80000000});
    send_set('{0, -1, 1, 32'sh7fffffff, 32'sh80000000, 32'sh80000001,
               32'sh7ffffffe, 5, 5, -3, 5});
    send_set('{-7, -7, -7});
    send_set('{3, 2});
    send_set('{-2, 0, 2, 100});
  endtask

  // exactly fills the store: no key dropped
  task automatic test_full_store();
    key_t set_keys[$];
    for (int i = 0; i < STORE_DEPTH; i++) set_keys.push_back(random_key());
    send_set(set_keys);
  endtask

  // two keys past capacity, the closing one among the dropped
  task automatic test_overflow_set();
    key_t set_keys[$];
    for (int i = 0; i < STORE_DEPTH + 2; i++) set_keys.push_back(random_key());
    send_set(set_keys);
  endtask

  task automatic test_random_sets(input int item_budget);
    int left;
    int set_len;
    left = item_budget;
    while (left > 0) begin
      set_len = ($urandom_range(99) < 80) ? $urandom_range(6, 1) : $urandom_range(20, 7);
      if (set_len > left) set_len = left;
      for (int i = 0; i < set_len; i++) send_key(random_key(), i == set_len - 1);
      left -= set_len;
    end
  endtask

  // result checker and receiver back-pressure
  always @(posedge clk) begin
    sorted_result_t want;
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: sorted_key %0d", $signed(results_ch.sorted_key));
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (results_ch.sorted_key !== want.sorted_key) begin
          $error("sorted_key: expected %0d, got %0d",
                 $signed(want.sorted_key), $signed(results_ch.sorted_key));
          fail_count++;
        end
        if (results_ch.last_result !== want.last_result) begin
          $error("last_result: expected %0b, got %0b", want.last_result,
                 results_ch.last_result);
          fail_count++;
        end
        if (results_ch.overflowed !== want.overflowed) begin
          $error("overflowed: expected %0b, got %0b", want.overflowed,
                 results_ch.overflowed);
          fail_count++;
        end
      end
    end
    results_ch.ready <= ($urandom_range(99) >= result_idle_pct);
  end

  // watchdog: cycles without any request moving on either channel
  always @(posedge clk) begin
    if (rst || (keys_ch.valid && keys_ch.ready) || (results_ch.valid && results_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    keys_ch.valid     <= 1'b0;
    keys_ch.key       <= '0;
    keys_ch.last_item <= 1'b0;
    set_overflowed  = 1'b0;
    key_idle_pct    = 19;
    result_idle_pct = 66;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_full_store();
    test_random_sets(72);

    key_idle_pct    = 66;
    result_idle_pct = 19;
    test_overflow_set();
    test_random_sets(72);

    key_idle_pct    = 0;
    result_idle_pct = 0;
    test_random_sets(72);

    keys_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
